@@ rtl/lmd_pkg.sv @@
`default_nettype none

package lmd_pkg;

	// Sample type shared by the window, the queue and the output stage.
	typedef logic signed [15:0] pix_t;

	// The eight neighbours of one candidate, in the order
	// up-left, up, up-right, left, right, down-left, down, down-right.
	typedef pix_t [7:0] nbr_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int RESET_DIM  = 5;
	localparam int POS_W      = 10;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 40;
	localparam int QDEPTH     = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

	// Candidate slots of one input, in raster order of the judged samples.
	localparam logic [1:0] SLOT_MID         = 2'd0;
	localparam logic [1:0] SLOT_RIGHT       = 2'd1;
	localparam logic [1:0] SLOT_BOTTOM      = 2'd2;
	localparam logic [1:0] SLOT_BOTTOM_RIGHT = 2'd3;

	// Position flags of one accepted sample.
	typedef struct packed {
		logic             r_ge1;
		logic             r_ge2;
		logic             c_ge1;
		logic             c_ge2;
		logic             last_col;
		logic             last_row;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} pos_t;

	// Decisions of one input that hold at least one report.
	typedef struct packed {
		logic [3:0]       mask;
		pix_t [3:0]       value;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} bundle_t;

endpackage

`default_nettype wire

@@ rtl/local_minimum_3x3_detector.sv @@
// 3x3 strict local minimum detector for a raster-order stream of signed samples.
// The slave channel (s_tvalid/s_tready/s_tdata) takes one 16-bit sample per beat,
// row by row with column 0 first. The master channel (m_tvalid/m_tready/m_tdata/
// m_tlast) gives one beat per local minimum found: its value, row and column. A
// sample is judged as soon as its last neighbour has arrived, so one input beat
// can cause zero to four output beats; m_tlast marks the last of them.
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the
// grid width (index 0) and height (index 1); values are clamped to 2..MAX and a
// write to either restarts the frame at row 0, column 0. It is always ready and
// should be written only while the stream is idle.
// Throughput: one input beat and, while m_tready is high, one output beat per
// cycle. An input beat is taken in every cycle except while the four-entry
// report queue is full and the new sample yields a report; this happens only
// when the sink stalls or several reports pile up at row and frame ends.
// On its way to the output register, the first report of a sample passes the
// stage that reads the line buffer and compares the window, then the report
// queue and the report serializer.
// Reset (arst_n low) empties the pipeline and queue, drops any pending output
// beat and restores width and height 5. When m_tready is low, the output beat
// holds, the queue fills, and then s_tready falls.
`default_nettype none

module local_minimum_3x3_detector #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// Configuration writes.
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [lmd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [lmd_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Sample stream.
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [lmd_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] pixel_value
	// Report stream.
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [lmd_pkg::M_TDATA_W-1:0]    m_tdata,   // [15:0] min_value, [25:16] min_row,
	                                                    // [35:26] min_col, [39:36] zero
	output logic                             m_tlast    // run_last
);

	lmd_pkg::bundle_t                push_data, pop_data;
	logic                            push, q_full, q_valid, pop;
	lmd_pkg::pix_t                   min_value;
	logic [lmd_pkg::POS_W-1:0]       min_row, min_col;

	// The register file has no side effects that need back pressure.
	assign cfg_ready = 1'b1;

	// Front: line buffer, 3x3 window and the four candidate tests.
	lmd_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.push     (push),
		.push_data(push_data),
		.q_full   (q_full)
	);

	// Only inputs with at least one report are queued.
	lmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.pop_data (pop_data)
	);

	// Back: sends the reports of one input one beat at a time in raster order.
	lmd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (pop_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.min_value(min_value),
		.min_row  (min_row),
		.min_col  (min_col),
		.run_last (m_tlast)
	);

	assign m_tdata = {4'b0000, min_col, min_row, min_value};

endmodule

`default_nettype wire

@@ rtl/lmd_front.sv @@
`default_nettype none

module lmd_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	input  wire  [lmd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [lmd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire  [lmd_pkg::S_TDATA_W-1:0]       s_tdata,
	output logic                                push,
	output lmd_pkg::bundle_t                    push_data,
	input  wire                                 q_full
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	function automatic int clamp_dim(input int v, input int hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return v;
	endfunction

	localparam logic [CW-1:0] RST_W_LAST = CW'(clamp_dim(lmd_pkg::RESET_DIM, MAX_WIDTH) - 1);
	localparam logic [RW-1:0] RST_H_LAST = RW'(clamp_dim(lmd_pkg::RESET_DIM, MAX_HEIGHT) - 1);

	function automatic logic [7:0] nbr_mask(input logic up, input logic down,
		input logic left, input logic right);
		return {down & right, down, down & left, right, left, up & right, up, up & left};
	endfunction

	function automatic logic is_min(input lmd_pkg::pix_t c, input lmd_pkg::nbr_t n,
		input logic [7:0] m);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (m[i] && !($signed(n[i]) > $signed(c))) ok = 1'b0;
		end
		return ok;
	endfunction

	logic [CW-1:0] w_last_q, col_q;
	logic [RW-1:0] h_last_q, row_q;
	logic          last_col, last_row, accept, s1_adv;
	logic [RW+lmd_pkg::POS_W-1:0] row_ext;
	logic [CW+lmd_pkg::POS_W-1:0] col_ext;

	logic          s1_valid_q;
	lmd_pkg::pix_t pix_s1;
	logic [CW-1:0] addr_s1;
	lmd_pkg::pos_t pos_s1;
	logic [31:0]   rd_s1;

	logic [31:0]   line_mem [MAX_WIDTH];

	lmd_pkg::pix_t win_q [3][3];
	lmd_pkg::pix_t nw    [3][3];
	lmd_pkg::nbr_t n0, n1, n2, n3;
	logic [3:0]    hits;

	assign last_col = (col_q == w_last_q);
	assign last_row = (row_q == h_last_q);
	assign accept   = s_tvalid && s_tready;
	assign row_ext  = {{lmd_pkg::POS_W{1'b0}}, row_q};
	assign col_ext  = {{lmd_pkg::POS_W{1'b0}}, col_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= RST_W_LAST;
			h_last_q <= RST_H_LAST;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lmd_pkg::CFG_GRID_WIDTH: begin
					w_last_q <= CW'(clamp_dim(int'(cfg_data), MAX_WIDTH) - 1);
					col_q    <= '0;
					row_q    <= '0;
				end
				lmd_pkg::CFG_GRID_HEIGHT: begin
					h_last_q <= RW'(clamp_dim(int'(cfg_data), MAX_HEIGHT) - 1);
					col_q    <= '0;
					row_q    <= '0;
				end
				default: ;
			endcase
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1          <= s_tdata;
			addr_s1         <= col_q;
			pos_s1.r_ge1    <= (row_q != '0);
			pos_s1.r_ge2    <= (row_q > RW'(1));
			pos_s1.c_ge1    <= (col_q != '0);
			pos_s1.c_ge2    <= (col_q > CW'(1));
			pos_s1.last_col <= last_col;
			pos_s1.last_row <= last_row;
			pos_s1.row      <= row_ext[lmd_pkg::POS_W-1:0];
			pos_s1.col      <= col_ext[lmd_pkg::POS_W-1:0];
		end
	end

	// Each entry holds the row two above in the upper half and the row
	// just above in the lower half.
	always_ff @(posedge clk) begin
		if (accept) rd_s1 <= line_mem[col_q];
		if (s1_adv) line_mem[addr_s1] <= {rd_s1[15:0], pix_s1};
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nw[k][0] = win_q[k][1];
			nw[k][1] = win_q[k][2];
		end
		nw[0][2] = rd_s1[31:16];
		nw[1][2] = rd_s1[15:0];
		nw[2][2] = pix_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) win_q <= nw;
	end

	// Positions a candidate cannot have are filled with its own value; the
	// mask keeps them out of the test.
	assign n0 = {nw[2][2], nw[2][1], nw[2][0], nw[1][2], nw[1][0], nw[0][2], nw[0][1], nw[0][0]};
	assign n1 = {nw[1][2], nw[2][2], nw[2][1], nw[1][2], nw[1][1], nw[1][2], nw[0][2], nw[0][1]};
	assign n2 = {nw[2][1], nw[2][1], nw[2][1], nw[2][2], nw[2][0], nw[1][2], nw[1][1], nw[1][0]};
	assign n3 = {nw[2][2], nw[2][2], nw[2][2], nw[2][2], nw[2][1], nw[2][2], nw[1][2], nw[1][1]};

	always_comb begin
		hits[lmd_pkg::SLOT_MID] = pos_s1.r_ge1 && pos_s1.c_ge1 &&
			is_min(nw[1][1], n0, nbr_mask(pos_s1.r_ge2, 1'b1, pos_s1.c_ge2, 1'b1));
		hits[lmd_pkg::SLOT_RIGHT] = pos_s1.r_ge1 && pos_s1.last_col &&
			is_min(nw[1][2], n1, nbr_mask(pos_s1.r_ge2, 1'b1, 1'b1, 1'b0));
		hits[lmd_pkg::SLOT_BOTTOM] = pos_s1.last_row && pos_s1.c_ge1 &&
			is_min(nw[2][1], n2, nbr_mask(1'b1, 1'b0, pos_s1.c_ge2, 1'b1));
		hits[lmd_pkg::SLOT_BOTTOM_RIGHT] = pos_s1.last_row && pos_s1.last_col &&
			is_min(nw[2][2], n3, nbr_mask(1'b1, 1'b0, 1'b1, 1'b0));
	end

	assign s1_adv   = s1_valid_q && ((hits == 4'b0) || !q_full);
	assign s_tready = !s1_valid_q || s1_adv;
	assign push     = s1_adv && (hits != 4'b0);

	always_comb begin
		push_data.mask     = hits;
		push_data.value[0] = nw[1][1];
		push_data.value[1] = nw[1][2];
		push_data.value[2] = nw[2][1];
		push_data.value[3] = nw[2][2];
		push_data.row      = pos_s1.row;
		push_data.col      = pos_s1.col;
	end

endmodule

`default_nettype wire

@@ rtl/lmd_queue.sv @@
`default_nettype none

module lmd_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  lmd_pkg::bundle_t push_data,
	output logic             full,
	input  wire              pop,
	output logic             valid,
	output lmd_pkg::bundle_t pop_data
);

	localparam int AW = $clog2(lmd_pkg::QDEPTH);
	localparam int NW = $clog2(lmd_pkg::QDEPTH + 1);

	lmd_pkg::bundle_t mem_q [lmd_pkg::QDEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [NW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full     = (cnt_q == NW'(lmd_pkg::QDEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + AW'(1);
			if (do_pop)  rd_q <= rd_q + AW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + NW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

endmodule

`default_nettype wire

@@ rtl/lmd_back.sv @@
`default_nettype none

module lmd_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          q_valid,
	input  lmd_pkg::bundle_t             q_data,
	output logic                         pop,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output lmd_pkg::pix_t                min_value,
	output logic [lmd_pkg::POS_W-1:0]    min_row,
	output logic [lmd_pkg::POS_W-1:0]    min_col,
	output logic                         run_last
);

	lmd_pkg::bundle_t work_q;
	logic [3:0]       mask_q, rem;
	logic [1:0]       sel;
	logic             out_free, fire, row_dec, col_dec;

	always_comb begin
		if (mask_q[0])      sel = lmd_pkg::SLOT_MID;
		else if (mask_q[1]) sel = lmd_pkg::SLOT_RIGHT;
		else if (mask_q[2]) sel = lmd_pkg::SLOT_BOTTOM;
		else                sel = lmd_pkg::SLOT_BOTTOM_RIGHT;
		rem      = mask_q & ~(4'b0001 << sel);
		out_free = !m_tvalid || m_tready;
		fire     = out_free && (mask_q != 4'b0);
		pop      = q_valid && ((mask_q == 4'b0) || (fire && (rem == 4'b0)));
		row_dec  = (sel == lmd_pkg::SLOT_MID) || (sel == lmd_pkg::SLOT_RIGHT);
		col_dec  = (sel == lmd_pkg::SLOT_MID) || (sel == lmd_pkg::SLOT_BOTTOM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (pop)       mask_q <= q_data.mask;
			else if (fire) mask_q <= rem;
			if (fire)          m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) work_q <= q_data;
		if (fire) begin
			min_value <= work_q.value[sel];
			min_row   <= work_q.row - {{(lmd_pkg::POS_W-1){1'b0}}, row_dec};
			min_col   <= work_q.col - {{(lmd_pkg::POS_W-1){1'b0}}, col_dec};
			run_last  <= (rem == 4'b0);
		end
	end

endmodule

`default_nettype wire

@@ rtl/lmd_checker.sv @@
`default_nettype none

module lmd_checker #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           m_tvalid,
	input wire                           m_tready,
	input wire [lmd_pkg::M_TDATA_W-1:0]  m_tdata,
	input wire                           m_tlast
);

	// A stalled report beat holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("report beat changed while stalled");

	// The remaining reports of one input follow without a gap.
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside the reports of one input");

	// Reported positions stay inside the largest grid.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (int'(m_tdata[35:26]) < MAX_WIDTH))
		else $error("reported column beyond the grid");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (int'(m_tdata[25:16]) < MAX_HEIGHT))
		else $error("reported row beyond the grid");

endmodule

bind local_minimum_3x3_detector lmd_checker #(
	.MAX_WIDTH (MAX_WIDTH),
	.MAX_HEIGHT(MAX_HEIGHT)
) u_lmd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

`default_nettype wire
